// ===== src/hashed_pixel_noise_generator_macros.svh =====
// Assertion macros shared by the hashed pixel noise generator sources.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef HASHED_PIXEL_NOISE_GENERATOR_MACROS_SVH
`define HASHED_PIXEL_NOISE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HPN_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hpn assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HPN_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hpn assertion failed");

`endif

// ===== src/hpn_pkg.sv =====
// Shared types, constants and hash helper functions of the noise generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hpn_pkg;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_NOISE_LEVEL   = 3'd0,
    REG_NOISE_MEAN    = 3'd1,
    REG_FRAME_SEED    = 3'd2,
    REG_CHANNEL_COUNT = 3'd3,
    REG_DEPTH_MODE    = 3'd4
  } cfg_idx_t;

  localparam logic [31:0] HASH_XOR  = 32'd61;
  localparam logic [31:0] HASH_MULT = 32'h27d4eb2d;

  localparam logic [19:0] LEVEL_RESET = 20'd32768;
  localparam logic [18:0] MEAN_RESET  = 19'd32768;
  localparam logic [2:0]  COUNT_RESET = 3'd4;

  localparam logic [15:0] FS_8BIT  = 16'h00FF;
  localparam logic [15:0] FS_16BIT = 16'hFFFF;

  localparam int NUM_CHAN = 4;

  // Pipeline stages: two shared seed stages, three lane stages, output register.
  localparam int STAGES = 6;
  localparam int ST_A   = 0;
  localparam int ST_B   = 1;
  localparam int ST_C   = 2;
  localparam int ST_D   = 3;
  localparam int ST_E   = 4;
  localparam int ST_O   = 5;

  typedef struct packed {
    logic [STAGES-1:0] en;
    logic [STAGES-1:0] valid;
  } pipe_ctrl_t;

  // Part of the integer mix that comes before the multiply.
  function automatic logic [31:0] mix_pre(input logic [31:0] a);
    logic [31:0] t;
    t = (a ^ HASH_XOR) ^ (a >> 16);
    t = t + (t << 3);
    t = t ^ (t >> 4);
    return t;
  endfunction

  // Part of the integer mix that follows the multiply.
  function automatic logic [31:0] mix_post(input logic [31:0] a);
    return a ^ (a >> 15);
  endfunction

endpackage

// ===== src/hpn_ctrl.sv =====
// Valid bits and stage enables of the noise pipeline, with bubble collapsing.
// Depends on hpn_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "hashed_pixel_noise_generator_macros.svh"

module hpn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_ready,
  output logic               in_ready,
  output hpn_pkg::pipe_ctrl_t ctrl
);
  import hpn_pkg::*;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] valid_nxt;
  logic [STAGES-1:0] en;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    en[ST_O] = !valid_r[ST_O] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
    valid_nxt = valid_r;
    if (en[0]) begin
      valid_nxt[0] = in_valid;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (en[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready   = en[0];
  assign ctrl.en    = en;
  assign ctrl.valid = valid_r;

  // Input is refused only when every stage holds a beat.
  `HPN_ASSERT_IMP(a_full_when_blocked, clk, rst_n, !in_ready, &valid_r)
  // A beat leaving the last lane stage lands in the output register.
  `HPN_ASSERT_NXT(a_last_to_out, clk, rst_n, valid_r[ST_E] && en[ST_O], valid_r[ST_O])
  // The output only becomes valid from a beat held in the last lane stage.
  `HPN_ASSERT_IMP(a_out_source, clk, rst_n, $rose(valid_r[ST_O]), $past(valid_r[ST_E]))

endmodule

// ===== src/hpn_seed_hash.sv =====
// Shared front stages: hashes the frame seed with the pixel column, then the row.
// Depends on hpn_pkg for the mix helpers and the pipeline control struct.
`timescale 1ns / 1ps

module hpn_seed_hash (
  input  logic                clk,
  input  hpn_pkg::pipe_ctrl_t ctrl,
  input  logic [31:0]         frame_seed,
  input  logic signed [15:0]  pixel_x,
  input  logic signed [15:0]  pixel_y,
  output logic [31:0]         row_prod
);
  import hpn_pkg::*;

  logic [31:0] col_prod_r;
  logic [15:0] y_r;
  logic [31:0] row_prod_r;
  logic [31:0] x_ext;
  logic [31:0] y_ext;

  assign x_ext = {{16{pixel_x[15]}}, pixel_x};
  assign y_ext = {{16{y_r[15]}}, y_r};

  // Each stage ends on the multiply; the tail of that mix runs in the next stage.
  always_ff @(posedge clk) begin
    if (ctrl.en[ST_A]) begin
      col_prod_r <= mix_pre(frame_seed ^ x_ext) * HASH_MULT;
      y_r        <= pixel_y;
    end
    if (ctrl.en[ST_B]) begin
      row_prod_r <= mix_pre(mix_post(col_prod_r) ^ y_ext) * HASH_MULT;
    end
  end

  assign row_prod = row_prod_r;

endmodule

// ===== src/hpn_lane.sv =====
// One channel lane: final hash with the channel index, scaling and clamping.
// Depends on hpn_pkg; fed by hpn_seed_hash and read by hpn_merge.
`timescale 1ns / 1ps

module hpn_lane #(
  parameter int LANE_ID = 0
) (
  input  logic                clk,
  input  hpn_pkg::pipe_ctrl_t ctrl,
  input  logic [31:0]         row_prod,
  input  logic [19:0]         scale_hi,
  input  logic [15:0]         scale_lo,
  input  logic [50:0]         center,
  input  logic [18:0]         noise_mean,
  input  logic [15:0]         full_scale,
  output logic [15:0]         code
);
  import hpn_pkg::*;

  logic [31:0] chan_prod_r;
  logic [31:0] hash;
  logic [51:0] prod_hi_r;
  logic [47:0] prod_lo_r;
  logic [53:0] sum_r;
  logic [54:0] diff;
  logic [21:0] quot;

  assign hash = mix_post(chan_prod_r);

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_C]) begin
      chan_prod_r <= mix_pre(mix_post(row_prod) ^ 32'(LANE_ID)) * HASH_MULT;
    end
    if (ctrl.en[ST_D]) begin
      prod_hi_r <= {20'b0, hash} * {32'b0, scale_hi};
      prod_lo_r <= {16'b0, hash} * {32'b0, scale_lo};
    end
    if (ctrl.en[ST_E]) begin
      sum_r <= {2'b0, prod_hi_r} + {22'b0, prod_lo_r[47:16]} + {3'b0, noise_mean, 32'b0};
    end
  end

  // Subtracting the midpoint term centers the hash; clamps to 0 and full_scale.
  always_comb begin
    diff = {1'b0, sum_r} - {4'b0, center};
    quot = diff[53:32];
    if (diff[54]) begin
      code = '0;
    end else if (quot > {6'b0, full_scale}) begin
      code = full_scale;
    end else begin
      code = quot[15:0];
    end
  end

endmodule

// ===== src/hpn_merge.sv =====
// Output register: gathers the lane codes and zeroes channels that are not enabled.
// Depends on hpn_pkg for the pipeline control struct and the channel count.
`timescale 1ns / 1ps

module hpn_merge #(
  parameter int LANES = 4
) (
  input  logic                clk,
  input  hpn_pkg::pipe_ctrl_t ctrl,
  input  logic [2:0]          channel_count,
  input  logic [15:0]         lane_code [LANES],
  output logic [15:0]         chan [hpn_pkg::NUM_CHAN]
);
  import hpn_pkg::*;

  logic [15:0] chan_r   [NUM_CHAN];
  logic [15:0] chan_nxt [NUM_CHAN];

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    if (c < LANES) begin : g_live
      assign chan_nxt[c] = (3'(c) < channel_count) ? lane_code[c] : 16'd0;
    end else begin : g_dead
      assign chan_nxt[c] = 16'd0;
    end

    always_ff @(posedge clk) begin
      if (ctrl.en[ST_O]) begin
        chan_r[c] <= chan_nxt[c];
      end
    end

    assign chan[c] = chan_r[c];
  end

endmodule

// ===== src/hashed_pixel_noise_generator.sv =====
// Top level of the hashed pixel noise generator: config registers, lanes, output.
// Depends on hpn_pkg, hpn_ctrl, hpn_seed_hash, hpn_lane and hpn_merge.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid/in_ready) takes one pixel coordinate per beat,
//   in_pixel_x and in_pixel_y as signed 16-bit values. The result channel
//   (out_valid/out_ready) returns one beat per pixel with four channel codes,
//   out_chan0..out_chan3; channels at or above channel_count read as zero.
//   The configuration channel (cfg_valid/cfg_ready) writes register
//   cfg_index with cfg_data; cfg_ready is always high and unknown indexes
//   are ignored. Write registers only while no pixel is in flight.
//   An accepted input beat passes six register stages before out_valid
//   (two shared seed hash stages, three lane stages for hash, scale
//   multiply and sum, and the output register), the first loading at the
//   accepting edge. Throughput is one pixel per clock unless the receiver
//   stalls: all lanes run side by side, each with its own multipliers.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   register defaults. When the receiver stalls, the output holds its beat
//   and empty stages behind it keep filling; in_ready drops only once every
//   stage holds a beat.
//
module hashed_pixel_noise_generator #(
  parameter int LANES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_pixel_x,
  input  logic signed [15:0] in_pixel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_chan0,
  output logic [15:0]        out_chan1,
  output logic [15:0]        out_chan2,
  output logic [15:0]        out_chan3,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import hpn_pkg::*;

  logic [19:0] noise_level_r;
  logic [18:0] noise_mean_r;
  logic [31:0] frame_seed_r;
  logic [2:0]  channel_count_r;
  logic        depth_mode_r;
  logic [35:0] scale_r;
  logic [35:0] scale_nxt;
  logic [15:0] full_scale;
  logic [31:0] row_prod;
  logic [15:0] lane_code [LANES];
  logic [15:0] chan [NUM_CHAN];
  pipe_ctrl_t  ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_level_r   <= LEVEL_RESET;
      noise_mean_r    <= MEAN_RESET;
      frame_seed_r    <= '0;
      channel_count_r <= COUNT_RESET;
      depth_mode_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_NOISE_LEVEL:   noise_level_r   <= cfg_data[19:0];
        REG_NOISE_MEAN:    noise_mean_r    <= cfg_data[18:0];
        REG_FRAME_SEED:    frame_seed_r    <= cfg_data;
        REG_CHANNEL_COUNT: channel_count_r <= cfg_data[2:0];
        REG_DEPTH_MODE:    depth_mode_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Full scale times level is L*2^16-L or L*2^8-L. It is registered in scale_r
  // behind the level register, ahead of any new beat reaching the scale multipliers.
  assign full_scale = depth_mode_r ? FS_16BIT : FS_8BIT;
  assign scale_nxt  = depth_mode_r ? ({noise_level_r, 16'b0} - {16'b0, noise_level_r})
                                   : ({8'b0, noise_level_r, 8'b0} - {16'b0, noise_level_r});

  always_ff @(posedge clk) begin
    scale_r <= scale_nxt;
  end

  hpn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctrl      (ctrl)
  );

  hpn_seed_hash u_seed (
    .clk        (clk),
    .ctrl       (ctrl),
    .frame_seed (frame_seed_r),
    .pixel_x    (in_pixel_x),
    .pixel_y    (in_pixel_y),
    .row_prod   (row_prod)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    hpn_lane #(
      .LANE_ID (l)
    ) u_lane (
      .clk        (clk),
      .ctrl       (ctrl),
      .row_prod   (row_prod),
      .scale_hi   (scale_r[35:16]),
      .scale_lo   (scale_r[15:0]),
      .center     ({scale_r, 15'b0}),
      .noise_mean (noise_mean_r),
      .full_scale (full_scale),
      .code       (lane_code[l])
    );
  end

  hpn_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk           (clk),
    .ctrl          (ctrl),
    .channel_count (channel_count_r),
    .lane_code     (lane_code),
    .chan          (chan)
  );

  assign out_valid = ctrl.valid[ST_O];
  assign out_chan0 = chan[0];
  assign out_chan1 = chan[1];
  assign out_chan2 = chan[2];
  assign out_chan3 = chan[3];

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the hashed pixel noise generator.
// Depends on hpn_pkg and hashed_pixel_noise_generator.
`timescale 1ns / 1ps

// Predicts the channel codes of each accepted pixel and checks the result beats in order.
class pixel_noise_scoreboard;
  localparam logic [31:0] MIX_XOR  = 32'd61;
  localparam logic [31:0] MIX_MULT = 32'h27d4eb2d;
  localparam logic [15:0] FULL_8   = 16'd255;
  localparam logic [15:0] FULL_16  = 16'd65535;

  int          lanes;
  logic [19:0] level;
  logic [18:0] mean;
  logic [31:0] seed;
  logic [2:0]  count;
  logic        depth;
  logic [3:0][15:0] expected_codes[$];
  int unsigned failures;

  function new(int lane_count);
    lanes    = lane_count;
    level    = 20'd32768;
    mean     = 19'd32768;
    seed     = 32'd0;
    count    = 3'd4;
    depth    = 1'b0;
    failures = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      hpn_pkg::REG_NOISE_LEVEL:   level = data[19:0];
      hpn_pkg::REG_NOISE_MEAN:    mean  = data[18:0];
      hpn_pkg::REG_FRAME_SEED:    seed  = data;
      hpn_pkg::REG_CHANNEL_COUNT: count = data[2:0];
      hpn_pkg::REG_DEPTH_MODE:    depth = data[0];
      default: ;
    endcase
  endfunction

  function logic [31:0] mix(logic [31:0] a);
    logic [31:0] t;
    t = (a ^ MIX_XOR) ^ (a >> 16);
    t = t + (t << 3);
    t = t ^ (t >> 4);
    t = t * MIX_MULT;
    return t ^ (t >> 15);
  endfunction

  // Exact value is (h - 2^31) * fs * level / 2^48 + mean, clamped and floored.
  // Both sides are scaled by 2^32 so the comparison stays in integers.
  function logic [15:0] scale_code(logic [31:0] h, logic [15:0] fs);
    logic [63:0] prod, prod_hi, prod_lo, biased, offset, code;
    prod    = 64'(fs) * 64'(level);
    prod_hi = prod >> 16;
    prod_lo = prod & 64'hFFFF;
    biased  = 64'(h) * prod_hi + ((64'(h) * prod_lo) >> 16) + (64'(mean) << 32);
    offset  = prod << 15;
    if (biased < offset) return 16'd0;
    code = (biased - offset) >> 32;
    if (code > 64'(fs)) return fs;
    return code[15:0];
  endfunction

  function void note_pixel(logic [15:0] x, logic [15:0] y);
    logic [31:0] base;
    logic [15:0] fs;
    logic [3:0][15:0] codes;
    fs   = depth ? FULL_16 : FULL_8;
    base = mix(mix(seed ^ {{16{x[15]}}, x}) ^ {{16{y[15]}}, y});
    for (int c = 0; c < 4; c++) begin
      if (c < lanes && c < count) codes[c] = scale_code(mix(base ^ 32'(c)), fs);
      else codes[c] = 16'd0;
    end
    expected_codes.insert(expected_codes.size(), codes);
  endfunction

  function void check_codes(logic [3:0][15:0] got);
    logic [3:0][15:0] want;
    if (expected_codes.size() == 0) begin
      $error("result beat with no pixel outstanding");
      failures++;
      return;
    end
    want = expected_codes.pop_front();
    for (int c = 0; c < 4; c++) begin
      if (got[c] !== want[c]) begin
        $error("out_chan%0d: expected %0d, got %0d", c, want[c], got[c]);
        failures++;
      end
    end
  endfunction

  function int pending();
    return expected_codes.size();
  endfunction
endclass

module testbench;
  localparam int LANES        = 4;
  localparam int SETTLE_DELAY = 10;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 119;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_pixel_x;
  logic signed [15:0] in_pixel_y;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        out_chan0;
  logic [15:0]        out_chan1;
  logic [15:0]        out_chan2;
  logic [15:0]        out_chan3;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit rx_hold = 1'b0;

  pixel_noise_scoreboard noise_check = new(LANES);

  hashed_pixel_noise_generator #(
    .LANES(LANES)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_chan0  (out_chan0),
    .out_chan1  (out_chan1),
    .out_chan2  (out_chan2),
    .out_chan3  (out_chan3),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) noise_check.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) noise_check.note_pixel(in_pixel_x, in_pixel_y);
      if (out_valid && out_ready) begin
        noise_check.check_codes({out_chan3, out_chan2, out_chan1, out_chan0});
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  // The receiver draws a stall before every beat unless calm; a hold request turns one stall
  // into a long stretch so the pipeline fills and backs up into the input.
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold) begin
        rx_hold = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pixel(input logic [15:0] x, input logic [15:0] y);
    int gap;
    in_valid   <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    do @(posedge clk); while (!in_ready);
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering pixels and waits until every outstanding beat has come back.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (noise_check.pending() != 0) @(posedge clk);
    repeat (SETTLE_DELAY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes every register, plus one random index above the last, which must be ignored.
  task automatic configure(input logic [31:0] level, input logic [31:0] mean,
                           input logic [31:0] seed, input logic [31:0] count,
                           input logic [31:0] depth);
    write_reg(3'(hpn_pkg::REG_DEPTH_MODE) + 3'($urandom_range(1, 3)), $urandom());
    write_reg(hpn_pkg::REG_NOISE_LEVEL, level);
    write_reg(hpn_pkg::REG_NOISE_MEAN, mean);
    write_reg(hpn_pkg::REG_FRAME_SEED, seed);
    write_reg(hpn_pkg::REG_CHANNEL_COUNT, count);
    write_reg(hpn_pkg::REG_DEPTH_MODE, depth);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] level, mean, seed, count;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults straight out of reset.
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'h8000, 16'h8000);
    send_pixel(16'h7FFF, 16'h7FFF);
    send_pixel(16'hFFFF, 16'h0001);
    send_pixel(16'h7FFF, 16'h8000);
    send_pixel(16'h8000, 16'h7FFF);
    drain_pipeline();

    // Level and mean at their widest codes, count above four, 16-bit depth.
    configure(32'h000F_FFFF, 32'h0007_FFFF, 32'hFFFF_FFFF, 32'd7, 32'd1);
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'h8000, 16'h7FFF);
    send_pixel(16'h5A5A, 16'hA5A5);
    send_pixel(16'hFFFF, 16'hFFFF);
    drain_pipeline();

    // No noise, no mean, no channels enabled.
    configure(32'd0, 32'd0, 32'h1234_5678, 32'd0, 32'd0);
    send_pixel(16'h0001, 16'h0002);
    send_pixel(16'h8000, 16'h8000);
    send_pixel(16'h7FFF, 16'hFFFF);
    drain_pipeline();

    // Top of the nominal ranges with one channel.
    configure(32'd655360, 32'd327680, 32'h0000_0000, 32'd1, 32'd1);
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'h1234, 16'hFEDC);
    send_pixel(16'h7FFF, 16'h8000);
    drain_pipeline();

    // Unity level, zero mean, two channels at 8-bit depth.
    configure(32'd65536, 32'd0, 32'hDEAD_BEEF, 32'd2, 32'd0);
    send_pixel(16'h0040, 16'h0030);
    send_pixel(16'hFFC0, 16'h0030);
    send_pixel(16'h8000, 16'h0000);
    drain_pipeline();

    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0:       level = 32'd0;
        1:       level = 32'h000F_FFFF;
        2:       level = 32'd655360;
        3:       level = $urandom();
        default: level = $urandom_range(0, 655360);
      endcase
      case ($urandom_range(0, 4))
        0:       mean = 32'd0;
        1:       mean = 32'h0007_FFFF;
        2:       mean = 32'd327680;
        3:       mean = $urandom();
        default: mean = $urandom_range(0, 327680);
      endcase
      seed  = $urandom();
      count = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 4);
      configure(level, mean, seed, count, $urandom());

      tx_calm = (phase == 2 || phase == 5);
      rx_calm = (phase == 5 || phase == 7);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 2 && i == 20) rx_hold = 1'b1;
        if (phase == 4 && i == PHASE_ITEMS / 2) drain_pipeline();
        send_pixel(pick_coord(), pick_coord());
      end
      drain_pipeline();
    end

    if (noise_check.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/hpn_pkg.sv
src/hpn_ctrl.sv
src/hpn_seed_hash.sv
src/hpn_lane.sv
src/hpn_merge.sv
src/hashed_pixel_noise_generator.sv
tb/testbench.sv
